// File: hw/rtl/ybar_pkg.sv
// Package: payload types, coefficient table and shared constants.
`default_nettype none
package ybar_pkg;

  localparam int unsigned MaxBoxSamplesDef = 256;
  localparam logic [13:0] HeightSplit = 14'd576;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic       box_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       box_overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    CfgColorSpace = 2'd0,
    CfgFullRange  = 2'd1,
    CfgJpeg       = 2'd2,
    CfgHeight     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CsBt709 = 2'd0,
    CsBt601 = 2'd1
  } cs_e;

  typedef struct packed {
    logic [4:0]         y_off;
    logic [9:0]         y_gain;
    logic signed [10:0] r_cr;
    logic signed [10:0] g_cb;
    logic signed [10:0] g_cr;
    logic signed [10:0] b_cb;
  } coef_t;

  // order: 601 limited, 709 limited, 601 full, 709 full
  function automatic coef_t coef_lookup(input logic [1:0] sel);
    coef_t c;
    unique case (sel)
      2'd0: c = '{5'd16, 10'd298, 11'sd409, -11'sd100, -11'sd208, 11'sd516};
      2'd1: c = '{5'd16, 10'd298, 11'sd459, -11'sd55, -11'sd136, 11'sd541};
      2'd2: c = '{5'd0, 10'd256, 11'sd359, -11'sd88, -11'sd183, 11'sd454};
      default: c = '{5'd0, 10'd256, 11'sd403, -11'sd48, -11'sd120, 11'sd475};
    endcase
    return c;
  endfunction

  // controller -> datapath
  typedef struct packed {
    logic acc_en;   // accumulate the input item
    logic div_start;
    logic div_step;
    logic conv;     // form products
    logic sum;      // add and clamp into output register
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/ybar_ctrl.sv
// Controller: sequences accumulate, divide, convert and output handoff.
`default_nettype none
module ybar_ctrl import ybar_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire logic    box_end_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output dp_cmd_t      cmd_o,
  input  wire dp_sts_t sts_i
);

  typedef enum logic [3:0] {
    StAcc  = 4'b0001,
    StDiv  = 4'b0010,
    StConv = 4'b0100,
    StSum  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;
  logic   acc;

  assign in_ready_o  = (state_q == StAcc);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    unique case (state_q)
      StAcc: begin
        cmd_o.acc_en = acc;
        if (acc && box_end_i) begin
          cmd_o.div_start = 1'b1;
          state_d = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = StConv;
      end
      StConv: begin
        cmd_o.conv = 1'b1;
        state_d = StSum;
      end
      StSum: begin
        if (!ovalid_d) begin
          cmd_o.sum = 1'b1;
          ovalid_d  = 1'b1;
          state_d   = StAcc;
        end
      end
      default: state_d = StAcc;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StAcc;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StAcc |-> !in_ready_o) else $error("ready while busy");
  a_sum_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sum |=> out_valid_o) else $error("result lost");
  a_div_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> state_q == StDiv) else $error("divide not entered");

endmodule
`default_nettype wire

// File: hw/rtl/ybar_dp.sv
// Datapath: box sums, serial divider, coefficient products, clamp.
`default_nettype none
module ybar_dp import ybar_pkg::*; #(
  parameter int unsigned MaxBoxSamples = MaxBoxSamplesDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_item_t in_i,
  input  wire logic [1:0] coef_sel_i,
  input  wire dp_cmd_t  cmd_i,
  output dp_sts_t       sts_o,
  output out_item_t     out_o
);

  localparam int unsigned CntW = $clog2(MaxBoxSamples + 1);
  localparam int unsigned SumW = 8 + CntW;
  localparam int unsigned StW  = $clog2(SumW + 1);

  logic [SumW-1:0] ys_q, bs_q, rs_q;
  logic [CntW-1:0] cnt_q;
  logic            drop_q;
  logic            full;

  assign full = (cnt_q == CntW'(MaxBoxSamples));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ys_q <= '0; bs_q <= '0; rs_q <= '0; cnt_q <= '0; drop_q <= 1'b0;
    end else if (cmd_i.sum) begin
      ys_q <= '0; bs_q <= '0; rs_q <= '0; cnt_q <= '0; drop_q <= 1'b0;
    end else if (cmd_i.acc_en) begin
      if (full) drop_q <= 1'b1;
      else begin
        ys_q  <= ys_q + SumW'(in_i.luma);
        bs_q  <= bs_q + SumW'(in_i.chroma_blue);
        rs_q  <= rs_q + SumW'(in_i.chroma_red);
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // restoring divider, three lanes, one quotient bit per cycle
  logic [SumW-1:0] qy_q, qb_q, qr_q;
  logic [CntW:0]   py_q, pb_q, pr_q;
  logic [StW-1:0]  step_q;
  logic [CntW-1:0] div_n;
  logic [CntW:0]   ty, tb, tr;
  logic            cy, cb, cr;

  assign div_n = (cnt_q == '0) ? CntW'(1) : cnt_q;
  assign ty = {py_q[CntW-1:0], qy_q[SumW-1]};
  assign tb = {pb_q[CntW-1:0], qb_q[SumW-1]};
  assign tr = {pr_q[CntW-1:0], qr_q[SumW-1]};
  assign cy = (ty >= {1'b0, div_n});
  assign cb = (tb >= {1'b0, div_n});
  assign cr = (tr >= {1'b0, div_n});
  assign sts_o.div_done = (step_q == StW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      qy_q <= full ? ys_q : ys_q + SumW'(in_i.luma);
      qb_q <= full ? bs_q : bs_q + SumW'(in_i.chroma_blue);
      qr_q <= full ? rs_q : rs_q + SumW'(in_i.chroma_red);
      py_q <= '0; pb_q <= '0; pr_q <= '0;
      step_q <= StW'(SumW);
    end else if (cmd_i.div_step) begin
      py_q <= cy ? ty - {1'b0, div_n} : ty;
      pb_q <= cb ? tb - {1'b0, div_n} : tb;
      pr_q <= cr ? tr - {1'b0, div_n} : tr;
      qy_q <= {qy_q[SumW-2:0], cy};
      qb_q <= {qb_q[SumW-2:0], cb};
      qr_q <= {qr_q[SumW-2:0], cr};
      step_q <= step_q - 1'b1;
    end
  end

  // averages fit 8 bits; products registered before the sum stage
  coef_t c;
  logic signed [9:0]  y9, u9, v9;
  logic signed [20:0] yy_q, rv_q, gu_q, gv_q, bu_q;
  logic drop_lat_q;
  assign c  = coef_lookup(coef_sel_i);
  assign y9 = $signed({2'b0, qy_q[7:0]}) - $signed({5'b0, c.y_off});
  assign u9 = $signed({2'b0, qb_q[7:0]}) - 10'sd128;
  assign v9 = $signed({2'b0, qr_q[7:0]}) - 10'sd128;

  always_ff @(posedge clk_i) begin
    if (cmd_i.conv) begin
      yy_q <= 21'(y9) * 21'($signed({1'b0, c.y_gain})) + 21'sd128;
      rv_q <= 21'(v9) * 21'(c.r_cr);
      gu_q <= 21'(u9) * 21'(c.g_cb);
      gv_q <= 21'(v9) * 21'(c.g_cr);
      bu_q <= 21'(u9) * 21'(c.b_cb);
      drop_lat_q <= drop_q;
    end
  end

  function automatic logic [7:0] to_byte(input logic signed [21:0] t);
    if (t < 0) return 8'd0;
    if (t[21:8] > 14'd255) return 8'd255;
    return t[15:8];
  endfunction

  logic signed [21:0] rt, gt, bt;
  assign rt = 22'(yy_q) + 22'(rv_q);
  assign gt = 22'(yy_q) + 22'(gu_q) + 22'(gv_q);
  assign bt = 22'(yy_q) + 22'(bu_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      out_o.red          <= to_byte(rt);
      out_o.green        <= to_byte(gt);
      out_o.blue         <= to_byte(bt);
      out_o.box_overflow <= drop_lat_q;
    end
  end

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxBoxSamples)) else $error("count over capacity");
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(drop_q) |-> $past(full)) else $error("drop without full box");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sum |=> cnt_q == '0) else $error("box not cleared");

endmodule
`default_nettype wire

// File: hw/rtl/yuv_box_average_to_rgb_core.sv
// Top level: config registers, controller and datapath.
// Throughput: one sample item per cycle inside a box; each box end then blocks
// input for the serial divide, one quotient bit per cycle, plus convert and the
// sum, which waits while the output register holds an unaccepted result.
// A result waits in the output register; the next box fills meanwhile.
// Reset (rst_ni low, async): sums, count, flags, state and config to defaults.
`default_nettype none
module yuv_box_average_to_rgb_core import ybar_pkg::*; #(
  parameter int unsigned MaxBoxSamples = MaxBoxSamplesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [13:0] cfg_data_i
);

  logic [1:0]  cs_q;
  logic        fr_q, jp_q;
  logic [13:0] h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q <= 2'd2; fr_q <= 1'b0; jp_q <= 1'b0; h_q <= 14'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgColorSpace: cs_q <= cfg_data_i[1:0];
        CfgFullRange:  fr_q <= cfg_data_i[0];
        CfgJpeg:       jp_q <= cfg_data_i[0];
        CfgHeight:     h_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic bt709;
  logic [1:0] sel;
  always_comb begin
    priority if (cs_q == CsBt709) bt709 = 1'b1;
    else if (cs_q == CsBt601) bt709 = 1'b0;
    else bt709 = (h_q > HeightSplit);
  end
  assign sel = {fr_q | jp_q, bt709};

  dp_cmd_t cmd;
  dp_sts_t sts;

  ybar_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .box_end_i(in_data_i.box_end), .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  ybar_dp #(.MaxBoxSamples(MaxBoxSamples)) u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .coef_sel_i(sel),
    .cmd_i(cmd), .sts_o(sts), .out_o(out_data_o)
  );

endmodule
`default_nettype wire

// File: tb/sv/yuv_box_average_to_rgb_core_tb.sv
// Testbench for the box-average YCbCr to RGB core: predicted results against the block.
`timescale 1ns / 100ps
`default_nettype none
module yuv_box_average_to_rgb_core_tb;
  import ybar_pkg::*;

  localparam int unsigned BoxCap = MaxBoxSamplesDef;
  localparam int WatchLimit = 20000;
  localparam int TailCycles = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [13:0] cfg_data_i = '0;

  yuv_box_average_to_rgb_core DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [1:0]  cs_q;
  logic        full_q, jpeg_q;
  logic [13:0] height_q;
  int unsigned ysum, bsum, rsum, nsamp;
  bit          dropped;
  out_item_t   rgb_pending[$];

  int  errors = 0;
  int  n_items = 0, n_results = 0, idle_cycles = 0;
  bit  hold_rx = 1'b0;
  bit  bursty = 1'b1;
  int  gap_left = 0;

  function automatic logic [7:0] clamp_byte(int t);
    if (t < 0) return 8'd0;
    return (t / 256 > 255) ? 8'd255 : 8'(t / 256);
  endfunction

  function automatic void predict_sample(in_item_t it);
    bit full, bt709;
    int c[6];
    int y, u, v, yy;
    out_item_t o;
    if (nsamp < BoxCap) begin
      ysum += it.luma; bsum += it.chroma_blue; rsum += it.chroma_red; nsamp++;
    end else dropped = 1'b1;
    if (!it.box_end) return;
    full = full_q || jpeg_q;
    if (cs_q == CsBt709) bt709 = 1;
    else if (cs_q == CsBt601) bt709 = 0;
    else bt709 = height_q > HeightSplit;
    case ({full, bt709})
      2'b00: c = '{16, 298, 409, -100, -208, 516};
      2'b01: c = '{16, 298, 459, -55, -136, 541};
      2'b10: c = '{0, 256, 359, -88, -183, 454};
      default: c = '{0, 256, 403, -48, -120, 475};
    endcase
    y = ysum / nsamp;
    u = int'(bsum / nsamp) - 128;
    v = int'(rsum / nsamp) - 128;
    yy = (y - c[0]) * c[1] + 128;
    o.red = clamp_byte(yy + c[2] * v);
    o.green = clamp_byte(yy + c[3] * u + c[4] * v);
    o.blue = clamp_byte(yy + c[5] * u);
    o.box_overflow = dropped;
    rgb_pending.push_back(o);
    ysum = 0; bsum = 0; rsum = 0; nsamp = 0; dropped = 0;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [13:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgColorSpace: cs_q = val[1:0];
      CfgFullRange:  full_q = val[0];
      CfgJpeg:       jpeg_q = val[0];
      default:       height_q = val;
    endcase
  endtask

  // valid stays up between back-to-back items; it drops only for a gap or a drain
  task automatic send_item(logic [7:0] y, logic [7:0] cb, logic [7:0] cr, logic last);
    in_item_t it;
    it = '{luma: y, chroma_blue: cb, chroma_red: cr, box_end: last};
    if (bursty) begin
      if (gap_left == 0) begin
        if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 6);
      end
      if (gap_left > 0) in_valid_i <= 1'b0;
      while (gap_left > 0) begin
        @(posedge clk_i);
        gap_left--;
      end
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_sample(it);
    n_items++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (rgb_pending.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic random_box(int maxlen);
    int len;
    len = $urandom_range(1, maxlen);
    for (int k = 0; k < len; k++)
      send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), k == len - 1);
  endtask

  task automatic test_directed();
    for (int s = 0; s < 4; s++) begin
      write_reg(CfgFullRange, 14'(s[0]));
      write_reg(CfgColorSpace, 14'(s[1] ? CsBt709 : CsBt601));
      send_item(8'd0, 8'd0, 8'd0, 1'b1);
      send_item(8'd255, 8'd255, 8'd255, 1'b1);
      send_item(8'd128, 8'd255, 8'd0, 1'b1);
      send_item(8'd16, 8'd0, 8'd255, 1'b0);
      send_item(8'd235, 8'd128, 8'd128, 1'b1);
      drain();
    end
  endtask

  task automatic test_config_sweep();
    logic [13:0] heights[4] = '{14'd1, 14'd576, 14'd577, 14'd8192};
    write_reg(CfgFullRange, 14'd0);
    for (int cs = 0; cs < 4; cs++) begin
      write_reg(CfgColorSpace, 14'(cs[1:0]));
      for (int h = 0; h < 4; h++) begin
        write_reg(CfgHeight, heights[h]);
        for (int j = 0; j < 2; j++) begin
          write_reg(CfgJpeg, 14'(j[0]));
          repeat (3) random_box(4);
          drain();
        end
      end
    end
  endtask

  // boxes at and beyond capacity: one ending exactly at it, one ending beyond it
  task automatic test_box_full();
    for (int n = BoxCap; n <= BoxCap + 3; n += 3)
      for (int k = 0; k < n; k++)
        send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), k == n - 1);
    drain();
  endtask

  task automatic test_random();
    int start;
    start = n_items;
    while (n_items - start < 450) begin
      if ($urandom_range(0, 9) == 0) begin
        drain();
        write_reg(cfg_idx_e'($urandom_range(0, 3)), 14'($urandom_range(1, 8192)));
      end
      bursty = $urandom_range(0, 3) != 0;
      random_box($urandom_range(0, 3) == 0 ? 40 : 6);
    end
    bursty = 1'b1;
    drain();
  endtask

  task automatic test_backpressure();
    hold_rx = 1'b1;
    bursty = 1'b0;
    repeat (6) random_box(3);
    hold_rx = 1'b0;
    bursty = 1'b1;
    drain();
  endtask

  // receiver stall pattern, plus a long hold-off on request
  initial begin
    int hold;
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        out_ready_i <= 1'b0;
        for (hold = 0; hold < 300; hold++) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      case ($urandom_range(0, 3))
        0: out_ready_i <= 1'b0;
        1: out_ready_i <= ($urandom_range(0, 1) == 1);
        default: out_ready_i <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin
    out_item_t exp_rgb;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (rgb_pending.size() == 0) begin
        $error("unexpected result %h", out_data_o);
        errors++;
      end else begin
        exp_rgb = rgb_pending.pop_front();
        if (out_data_o.red !== exp_rgb.red) begin
          $error("red: expected %0d actual %0d", exp_rgb.red, out_data_o.red); errors++;
        end
        if (out_data_o.green !== exp_rgb.green) begin
          $error("green: expected %0d actual %0d", exp_rgb.green, out_data_o.green); errors++;
        end
        if (out_data_o.blue !== exp_rgb.blue) begin
          $error("blue: expected %0d actual %0d", exp_rgb.blue, out_data_o.blue); errors++;
        end
        if (out_data_o.box_overflow !== exp_rgb.box_overflow) begin
          $error("box_overflow: expected %0d actual %0d",
                 exp_rgb.box_overflow, out_data_o.box_overflow);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no item moving on either side and no config write
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("timeout with %0d results pending", rgb_pending.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    cs_q = 2'd2; full_q = 0; jpeg_q = 0; height_q = 14'd1;
    ysum = 0; bsum = 0; rsum = 0; nsamp = 0; dropped = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_config_sweep();
    test_box_full();
    test_backpressure();
    test_random();
    if (rgb_pending.size() != 0) begin
      $error("%0d results never arrived", rgb_pending.size());
      errors++;
    end
    $display("Covered %0d samples and %0d boxes over all coefficient sets,", n_items, n_results);
    $display("capacity overflow, output back-pressure and random config changes.");
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire
